### rtl/core/mfr_pkg.sv
// mfr_pkg: shared constants for the multitap feedback reverb.
// Depends on nothing; used by mfr_cfg_if, the top level and the bench.
package mfr_pkg;

    localparam int DELAY_BITS    = 12;
    localparam int GAIN_BITS     = 16;
    localparam int FRAC_BITS     = 15;
    localparam int REG_TAPS      = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP1_DELAY = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP2_DELAY = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP3_DELAY = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP1_GAIN  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP2_GAIN  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP3_GAIN  = 3'd5;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET [REG_TAPS] = '{
        12'd1009, 12'd2011, 12'd3001
    };

    // 0.40, 0.30, 0.20 in Q1.15
    localparam logic signed [GAIN_BITS-1:0] GAIN_RESET [REG_TAPS] = '{
        16'sd13107, 16'sd9830, 16'sd6554
    };

endpackage

### rtl/core/mfr_sample_if.sv
// mfr_sample_if: input sample channel, valid/ready plus one sample.
// Depends on nothing.
interface mfr_sample_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

### rtl/core/mfr_result_if.sv
// mfr_result_if: result channel, valid/ready plus output sample and clip flag.
// Depends on nothing.
interface mfr_result_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

### rtl/core/mfr_cfg_if.sv
// mfr_cfg_if: configuration write channel, valid/ready plus index and data.
// Depends on mfr_pkg for the index and data widths.
interface mfr_cfg_if ();
    import mfr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/multitap_feedback_reverb_unit.sv
// multitap_feedback_reverb_unit: one-channel comb reverb with feedback taps.
// Depends on mfr_pkg, mfr_sample_if, mfr_result_if, mfr_cfg_if.
//
// Channels: i_sample takes one signed sample per request, o_result returns one
// saturated sample and a clip flag per request, i_cfg writes the tap delays
// (index 0..2) and Q1.15 gains (index 3..5); other indexes are ignored.
// The single history memory port serves TAP_COUNT tap reads plus one write-back
// slot per sample; the next sample enters while the previous one finishes its
// sum. Each sample's taps are read, multiplied and summed in turn, and the
// result enters the result queue once the last tap is added.
// A delay write is reduced modulo HISTORY_DEPTH by restoring compare/subtract
// steps (none when the depth is 4096 or more), during which no sample is taken.
// Reset: registers return to their defaults and the write pointer to zero.
// History entries not yet written since reset read as zero; there is no
// clearing pass. A two-entry result queue lets work go on while the receiver
// stalls; with two requests outstanding, input ready drops.
module multitap_feedback_reverb_unit #(
    parameter int HISTORY_DEPTH = 4096,
    parameter int SAMPLE_BITS   = 16,
    parameter int TAP_COUNT     = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mfr_sample_if.sink   i_sample,
    mfr_result_if.source o_result,
    mfr_cfg_if.sink      i_cfg
);
    import mfr_pkg::*;

    localparam int AW        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int PW        = $clog2(TAP_COUNT + 1);
    localparam int PRODW     = SAMPLE_BITS + GAIN_BITS;
    localparam int ACCW      = PRODW + $clog2(TAP_COUNT + 1) + 1;
    localparam int RED_STEPS =
        $clog2(((1 << DELAY_BITS) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
    localparam int RJW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    localparam logic signed [ACCW-1:0] Y_MAX =
        {{(ACCW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACCW-1:0] Y_MIN =
        {{(ACCW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    // configuration
    logic        [AW-1:0]         r_delay [REG_TAPS];
    logic signed [GAIN_BITS-1:0]  r_gain  [REG_TAPS];
    logic                         r_red_busy;
    logic        [DELAY_BITS-1:0] r_red_val;
    logic        [1:0]            r_red_tap;
    logic        [RJW-1:0]        r_red_j;
    logic        [31:0]           red_mod;
    logic        [DELAY_BITS-1:0] red_next;
    logic                         cfg_fire;

    // sequencer and item registers
    logic                          r_busy;
    logic        [PW-1:0]          r_phase;
    logic        [AW-1:0]          r_wp;
    logic                          r_full;
    logic        [AW-1:0]          r_item_wp;
    logic                          r_item_full;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic        [1:0]             r_pending;
    logic                          in_fire;
    logic                          out_fire;

    // memory and read issue
    logic        [SAMPLE_BITS-1:0] r_mem [HISTORY_DEPTH];
    logic        [SAMPLE_BITS-1:0] r_mem_q;
    logic                          mem_re;
    logic                          mem_we;
    logic        [AW-1:0]          rd_delay;
    logic        [AW:0]            rd_diff;
    logic        [AW-1:0]          rd_addr;
    logic                          r_rd_vld;
    logic        [AW-1:0]          r_rd_addr;
    logic                          r_rd_zero;
    logic                          r_rd_first;
    logic                          r_rd_last;
    logic        [PW-1:0]          r_rd_tap;

    // pending write-back of the latest output
    logic                          r_pend_vld;
    logic        [AW-1:0]          r_pend_addr;
    logic        [SAMPLE_BITS-1:0] r_pend_data;

    // multiply and accumulate
    logic signed [SAMPLE_BITS-1:0] hist;
    logic signed [GAIN_BITS-1:0]   tap_gain;
    logic signed [PRODW-1:0]       prod;
    logic signed [PRODW-1:0]       r_prod;
    logic                          r_prod_vld;
    logic                          r_prod_first;
    logic                          r_prod_last;
    logic signed [SAMPLE_BITS-1:0] r_base;
    logic        [AW-1:0]          r_fin_wp;
    logic signed [ACCW-1:0]        r_acc;
    logic signed [ACCW-1:0]        sum_in;
    logic signed [ACCW-1:0]        total;
    logic signed [ACCW-1:0]        y_floor;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          y_clip;
    logic                          fin;

    // result queue
    logic signed [SAMPLE_BITS-1:0] r_q_data [2];
    logic                          r_q_clip [2];
    logic                          r_q_wr;
    logic                          r_q_rd;
    logic        [1:0]             r_q_cnt;

    // ---------------- configuration ----------------
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = !r_red_busy;

    // delay mod depth, one restoring compare/subtract per cycle
    assign red_mod  = 32'(HISTORY_DEPTH) << r_red_j;
    assign red_next = ({20'b0, r_red_val} >= red_mod) ?
                      r_red_val - red_mod[DELAY_BITS-1:0] : r_red_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_busy <= 1'b0;
            for (int k = 0; k < REG_TAPS; k++) begin
                r_delay[k] <= AW'(DELAY_RESET[k] % HISTORY_DEPTH);
                r_gain[k]  <= GAIN_RESET[k];
            end
        end else if (r_red_busy) begin
            r_red_val <= red_next;
            if (r_red_j == '0) begin
                r_delay[r_red_tap] <= AW'(red_next);
                r_red_busy         <= 1'b0;
            end else begin
                r_red_j <= r_red_j - 1'b1;
            end
        end else if (cfg_fire) begin
            case (i_cfg.index)
                CFG_TAP1_DELAY, CFG_TAP2_DELAY, CFG_TAP3_DELAY: begin
                    if (RED_STEPS == 0) begin
                        r_delay[2'(i_cfg.index - CFG_TAP1_DELAY)] <=
                            AW'(i_cfg.data[DELAY_BITS-1:0]);
                    end else begin
                        r_red_busy <= 1'b1;
                        r_red_val  <= i_cfg.data[DELAY_BITS-1:0];
                        r_red_tap  <= 2'(i_cfg.index - CFG_TAP1_DELAY);
                        r_red_j    <= RJW'(RED_STEPS - 1);
                    end
                end
                CFG_TAP1_GAIN, CFG_TAP2_GAIN, CFG_TAP3_GAIN: begin
                    r_gain[2'(i_cfg.index - CFG_TAP1_GAIN)] <= $signed(i_cfg.data);
                end
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign in_fire        = i_sample.valid && i_sample.ready;
    assign out_fire       = o_result.valid && o_result.ready;
    assign i_sample.ready = !r_red_busy && (r_pending < 2'd2) &&
                            (!r_busy || r_phase == PW'(TAP_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_phase   <= '0;
            r_wp      <= '0;
            r_full    <= 1'b0;
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_fire} - {1'b0, out_fire};
            if (in_fire) begin
                r_busy      <= 1'b1;
                r_phase     <= '0;
                r_item_wp   <= r_wp;
                r_item_full <= r_full;
                r_x         <= i_sample.sample_in;
                if (r_wp == AW'(HISTORY_DEPTH - 1)) begin
                    r_wp   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end else if (r_busy) begin
                if (r_phase == PW'(TAP_COUNT)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end
        end
    end

    // ---------------- read issue ----------------
    always_comb begin
        rd_delay = '0;
        for (int k = 0; k < REG_TAPS; k++) begin
            if (k < TAP_COUNT && r_phase == PW'(k)) begin
                rd_delay = r_delay[k];
            end
        end
    end

    assign rd_diff = {1'b0, r_item_wp} - {1'b0, rd_delay};
    assign rd_addr = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(HISTORY_DEPTH))
                                 : rd_diff[AW-1:0];
    assign mem_re  = r_busy && (r_phase < PW'(TAP_COUNT));
    // the port writes back only in a slot with no tap read
    assign mem_we  = r_pend_vld && !mem_re;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pend_addr] <= r_pend_data;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld   <= mem_re;
            r_rd_addr  <= rd_addr;
            // entries past the write pointer are unwritten until the first wrap
            r_rd_zero  <= !(r_item_full || rd_addr < r_item_wp);
            r_rd_first <= (r_phase == '0);
            r_rd_last  <= (r_phase == PW'(TAP_COUNT - 1));
            r_rd_tap   <= r_phase;
        end
    end

    // ---------------- multiply ----------------
    // the newest output may still sit in the write-back register
    assign hist = (r_pend_vld && r_pend_addr == r_rd_addr) ? $signed(r_pend_data) :
                  r_rd_zero ? '0 : $signed(r_mem_q);

    always_comb begin
        tap_gain = '0;
        for (int k = 0; k < REG_TAPS; k++) begin
            if (k < TAP_COUNT && r_rd_tap == PW'(k)) begin
                tap_gain = r_gain[k];
            end
        end
    end

    assign prod = tap_gain * hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= r_rd_vld;
            if (r_rd_vld) begin
                r_prod       <= prod;
                r_prod_first <= r_rd_first;
                r_prod_last  <= r_rd_last;
                if (r_rd_first) begin
                    r_base <= r_x;
                end
                if (r_rd_last) begin
                    r_fin_wp <= r_item_wp;
                end
            end
        end
    end

    // ---------------- accumulate, floor, saturate ----------------
    assign sum_in  = r_prod_first ? (ACCW'(r_base) <<< (FRAC_BITS - 1)) : r_acc;
    assign total   = sum_in + ACCW'(r_prod);
    assign y_floor = total >>> FRAC_BITS;
    assign fin     = r_prod_vld && r_prod_last;

    always_comb begin
        y_clip = 1'b0;
        y_sat  = y_floor[SAMPLE_BITS-1:0];
        if (y_floor > Y_MAX) begin
            y_sat  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            y_clip = 1'b1;
        end else if (y_floor < Y_MIN) begin
            y_sat  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            y_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_q_wr     <= 1'b0;
            r_q_rd     <= 1'b0;
            r_q_cnt    <= '0;
        end else begin
            if (r_prod_vld && !r_prod_last) begin
                r_acc <= total;
            end
            if (fin) begin
                r_pend_vld         <= 1'b1;
                r_pend_addr        <= r_fin_wp;
                r_pend_data        <= y_sat;
                r_q_data[r_q_wr]   <= y_sat;
                r_q_clip[r_q_wr]   <= y_clip;
                r_q_wr             <= !r_q_wr;
            end else if (mem_we) begin
                r_pend_vld <= 1'b0;
            end
            if (out_fire) begin
                r_q_rd <= !r_q_rd;
            end
            r_q_cnt <= r_q_cnt + {1'b0, fin} - {1'b0, out_fire};
        end
    end

    assign o_result.valid      = (r_q_cnt != '0);
    assign o_result.sample_out = r_q_data[r_q_rd];
    assign o_result.clipped    = r_q_clip[r_q_rd];

`ifndef ASSERT_OFF
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("more than two requests outstanding");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> (r_q_cnt < 2'd2 || out_fire))
        else $error("result produced with a full queue");

    a_pend_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> !r_pend_vld)
        else $error("write-back overwritten before reaching memory");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= r_pending)
        else $error("queue holds more results than outstanding requests");

    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_phase == '0 && mem_re))
        else $error("accepted sample did not start its tap reads");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for multitap_feedback_reverb_unit (comb reverb, three feedback taps).
// Depends on mfr_pkg, the three channel interfaces and the RTL top level.
module tb;
    import mfr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SAMPLE_W    = 16;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 120;
    localparam int MAX_REPORTS = 50;
    // indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clip;
    } reverb_out_t;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } tap_write_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mfr_sample_if #(.SAMPLE_BITS(SAMPLE_W)) sample_ch ();
    mfr_result_if #(.SAMPLE_BITS(SAMPLE_W)) result_ch ();
    mfr_cfg_if cfg_ch ();

    multitap_feedback_reverb_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the block state
    logic signed [SAMPLE_W-1:0]   echo_hist [4096];
    logic [DELAY_BITS-1:0]        echo_wr_ptr;
    logic [DELAY_BITS-1:0]        tap_delay [REG_TAPS];
    logic signed [GAIN_BITS-1:0]  tap_gain [REG_TAPS];

    logic [SAMPLE_W-1:0] samples_todo [$];
    tap_write_t          tap_writes [$];
    reverb_out_t         due_outputs [$];

    int unsigned sample_gap = 0;
    int unsigned cfg_gap = 0;
    int unsigned rdy_hold = 0;
    int          cycle_count = 0;
    int          err_count = 0;
    int          checked_count = 0;
    int          clip_count = 0;
    int          write_count = 0;
    bit          no_idle = 1'b0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void apply_tap_write(input tap_write_t w);
        write_count++;
        case (w.index)
            CFG_TAP1_DELAY: tap_delay[0] = w.data[DELAY_BITS-1:0];
            CFG_TAP2_DELAY: tap_delay[1] = w.data[DELAY_BITS-1:0];
            CFG_TAP3_DELAY: tap_delay[2] = w.data[DELAY_BITS-1:0];
            CFG_TAP1_GAIN:  tap_gain[0] = w.data;
            CFG_TAP2_GAIN:  tap_gain[1] = w.data;
            CFG_TAP3_GAIN:  tap_gain[2] = w.data;
            default: ;
        endcase
    endfunction

    // y = x/2 + sum gain_k * y[n - delay_k], floored then saturated
    function automatic void reverb_step(input logic signed [SAMPLE_W-1:0] x);
        longint                acc;
        longint                y;
        logic [DELAY_BITS-1:0] rd;
        reverb_out_t           r;
        int                    k;
        acc = longint'(x) * 16384;
        for (k = 0; k < REG_TAPS; k++) begin
            rd = echo_wr_ptr - tap_delay[k];   // delay 0 lands on the oldest entry
            acc += longint'(tap_gain[k]) * longint'(echo_hist[rd]);
        end
        y = acc >>> FRAC_BITS;
        r.clip = 1'b0;
        if (y > 32767) begin
            y = 32767;
            r.clip = 1'b1;
        end else if (y < -32768) begin
            y = -32768;
            r.clip = 1'b1;
        end
        r.sample = y[SAMPLE_W-1:0];
        echo_hist[echo_wr_ptr] = r.sample;
        echo_wr_ptr = echo_wr_ptr + 1'b1;
        due_outputs.push_back(r);
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
            sample_ch.sample_in <= '0;
            sample_gap <= 0;
        end else begin
            if (sample_ch.valid && sample_ch.ready)
                reverb_step(sample_ch.sample_in);
            if (!sample_ch.valid || sample_ch.ready) begin
                if (sample_gap != 0) begin
                    sample_ch.valid <= 1'b0;
                    sample_gap <= sample_gap - 1;
                end else if (samples_todo.size() != 0) begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.sample_in <= samples_todo.pop_front();
                    sample_gap <= pick_gap();
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // register write driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data <= '0;
            cfg_gap <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                apply_tap_write('{index: cfg_ch.index, data: cfg_ch.data});
            if (!cfg_ch.valid || cfg_ch.ready) begin
                if (cfg_gap != 0) begin
                    cfg_ch.valid <= 1'b0;
                    cfg_gap <= cfg_gap - 1;
                end else if (tap_writes.size() != 0) begin
                    tap_write_t w;
                    w = tap_writes.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= w.index;
                    cfg_ch.data <= w.data;
                    cfg_gap <= pick_gap();
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            rdy_hold <= 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (due_outputs.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected result sample %0d clipped %0b", $time,
                                 $signed(result_ch.sample_out), result_ch.clipped);
                end else begin
                    reverb_out_t want;
                    want = due_outputs.pop_front();
                    checked_count++;
                    if (want.clip)
                        clip_count++;
                    if (result_ch.sample_out !== want.sample) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: sample_out expected %0d actual %0d", $time,
                                     want.sample, $signed(result_ch.sample_out));
                    end
                    if (result_ch.clipped !== want.clip) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: clipped expected %0b actual %0b", $time,
                                     want.clip, result_ch.clipped);
                    end
                end
            end
            if (rdy_hold != 0) begin
                result_ch.ready <= 1'b0;
                rdy_hold <= rdy_hold - 1;
            end else begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    rdy_hold <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     due_outputs.size());
            $display("[multitap_feedback_reverb_unit] ERROR");
            $finish;
        end
    end

    task automatic push_write(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] d);
        tap_writes.push_back('{index: idx, data: d});
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (samples_todo.size() != 0 || tap_writes.size() != 0 || sample_ch.valid
               || cfg_ch.valid || due_outputs.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample(input logic [15:0] prev);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'($urandom);
        if (r < 75)
            return 16'($urandom_range(0, 1023) - 512);
        if (r < 90) begin
            case ($urandom_range(0, 3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'hFFFF;
                default: return 16'h0000;
            endcase
        end
        return prev;   // repeated value builds up a DC level
    endfunction

    // upper nibble is junk that the delay register must drop
    function automatic logic [15:0] rand_delay_word();
        logic [11:0] d;
        case ($urandom_range(0, 5))
            0: d = 12'($urandom_range(1, 8));
            1: d = 12'($urandom_range(9, 64));
            2: d = 12'($urandom_range(65, 1500));
            3: d = '0;
            4: d = '1;
            default: d = 12'($urandom);
        endcase
        return {4'($urandom), d};
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 6))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 16383) - 8192);
            2: return 16'h7FFF;
            3: return 16'h8001;
            4: return 16'h8000;
            5: return 16'h0000;
            default: return 16'($urandom_range(8192, 16384));
        endcase
    endfunction

    initial begin
        int          p;
        int          n;
        logic [15:0] s;

        foreach (echo_hist[i])
            echo_hist[i] = '0;
        echo_wr_ptr = '0;
        for (n = 0; n < REG_TAPS; n++) begin
            tap_delay[n] = DELAY_RESET[n];
            tap_gain[n] = GAIN_RESET[n];
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: all tap reads still hit cleared history
        samples_todo = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF,
                         16'h5555, 16'hAAAA, 16'h4000};
        s = 0;
        for (n = 0; n < 100; n++) begin
            s = rand_sample(s);
            samples_todo.push_back(s);
        end
        wait_idle();

        // delay 0 (= full depth), max delay, gain of exactly -1.0
        push_write(CFG_TAP1_DELAY, 16'hF000);
        push_write(CFG_TAP2_DELAY, 16'h0FFF);
        push_write(CFG_TAP3_DELAY, 16'h0001);
        push_write(CFG_TAP1_GAIN, 16'h8000);
        push_write(CFG_TAP2_GAIN, 16'h7FFF);
        push_write(CFG_TAP3_GAIN, 16'h8000);
        wait_idle();
        samples_todo = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000};
        wait_idle();

        // full positive feedback on short delays: drives the output into clipping
        push_write(CFG_TAP1_DELAY, 16'h0001);
        push_write(CFG_TAP2_DELAY, 16'h0002);
        push_write(CFG_TAP3_DELAY, 16'h0003);
        push_write(CFG_TAP1_GAIN, 16'h7FFF);
        push_write(CFG_TAP2_GAIN, 16'h7FFF);
        push_write(CFG_TAP3_GAIN, 16'h7FFF);
        push_write(CFG_SPARE_LO, 16'hFFFF);
        push_write(CFG_SPARE_HI, 16'hFFFF);
        wait_idle();
        samples_todo = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                         16'h8000, 16'h8000, 16'h8000, 16'h8000};
        wait_idle();

        for (p = 0; p < PHASES; p++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                push_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
            if ($urandom_range(0, 4) != 0) push_write(CFG_TAP1_DELAY, rand_delay_word());
            if ($urandom_range(0, 4) != 0) push_write(CFG_TAP2_DELAY, rand_delay_word());
            if ($urandom_range(0, 4) != 0) push_write(CFG_TAP3_DELAY, rand_delay_word());
            if ($urandom_range(0, 4) != 0) push_write(CFG_TAP1_GAIN, rand_gain());
            if ($urandom_range(0, 4) != 0) push_write(CFG_TAP2_GAIN, rand_gain());
            if ($urandom_range(0, 4) != 0) push_write(CFG_TAP3_GAIN, rand_gain());
            wait_idle();
            s = 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                s = rand_sample(s);
                samples_todo.push_back(s);
            end
            wait_idle();
        end

        no_idle = 1'b0;
        repeat (20) @(posedge i_clk);
        $display("checked %0d reverb samples (%0d saturated) across %0d tap settings,",
                 checked_count, clip_count, PHASES + 3);
        $display("%0d register writes accepted, %0d mismatches", write_count, err_count);
        if (err_count == 0 && due_outputs.size() == 0)
            $display("[multitap_feedback_reverb_unit] OK");
        else
            $display("[multitap_feedback_reverb_unit] ERROR");
        $finish;
    end
endmodule

### files.f
rtl/core/mfr_pkg.sv
rtl/core/mfr_sample_if.sv
rtl/core/mfr_result_if.sv
rtl/core/mfr_cfg_if.sv
rtl/core/multitap_feedback_reverb_unit.sv
bench/tb.sv
